[rtl/crce_pkg.sv]
// Shared types and constants of the capacitated route cost evaluator.
package crce_pkg;

   localparam int KIND_BITS        = 2;
   localparam int POINT_FIELD_BITS = 8;
   localparam int VALUE_FIELD_BITS = 16;
   localparam int LOAD_BITS        = 16;
   localparam int COST_BITS        = 32;

   localparam logic [KIND_BITS-1:0] KIND_DEMAND = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_DIST   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_VISIT  = 2'd2;

   localparam logic [LOAD_BITS-1:0] CAPACITY_RESET = 16'hFFFF;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EVAL  = 5'b00010,
      ST_RET   = 5'b00100,
      ST_LEG   = 5'b01000,
      ST_CLOSE = 5'b10000
   } state_type;

   typedef struct packed {
      logic dem_we;
      logic dist_we;
      logic dem_re;
      logic dist_re;
   } tbl_ctrl_type;

endpackage

[rtl/crce_tables.sv]
// Demand and distance table memories with registered read ports.
module crce_tables #(
   parameter int MAX_POINTS = 256,
   parameter int VALUE_BITS = 16
) (
   input  logic                             clock,
   input  crce_pkg::tbl_ctrl_type           tbl_ctrl,
   input  logic [$clog2(MAX_POINTS)-1:0]    wr_row,
   input  logic [$clog2(MAX_POINTS)-1:0]    wr_col,
   input  logic [VALUE_BITS-1:0]            wr_data,
   input  logic [$clog2(MAX_POINTS)-1:0]    dem_raddr,
   input  logic [2*$clog2(MAX_POINTS)-1:0]  dist_raddr,
   output logic [VALUE_BITS-1:0]            dem_rdata,
   output logic [VALUE_BITS-1:0]            dist_rdata
);
   import crce_pkg::*;

   localparam int PB         = $clog2(MAX_POINTS);
   localparam int DIST_DEPTH = 2 ** (2 * PB);

   logic [VALUE_BITS-1:0] dem_mem  [MAX_POINTS];
   logic [VALUE_BITS-1:0] dist_mem [DIST_DEPTH];
   logic [VALUE_BITS-1:0] dem_rd_ff;
   logic [VALUE_BITS-1:0] dist_rd_ff;

   always_ff @(posedge clock) begin
      if (tbl_ctrl.dem_we) begin
         dem_mem[wr_row] <= wr_data;
      end
      if (tbl_ctrl.dem_re) begin
         dem_rd_ff <= dem_mem[dem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_ctrl.dist_we) begin
         dist_mem[{wr_row, wr_col}] <= wr_data;
      end
      if (tbl_ctrl.dist_re) begin
         dist_rd_ff <= dist_mem[dist_raddr];
      end
   end

   assign dem_rdata  = dem_rd_ff;
   assign dist_rdata = dist_rd_ff;

endmodule

[rtl/crce_engine.sv]
// Visit sequencer: route state, table access control and result register.
module crce_engine #(
   parameter int MAX_POINTS = 256,
   parameter int VALUE_BITS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [crce_pkg::KIND_BITS-1:0]              req_kind,
   input  logic [crce_pkg::POINT_FIELD_BITS-1:0]       req_point,
   input  logic [crce_pkg::POINT_FIELD_BITS-1:0]       req_other_point,
   input  logic [crce_pkg::VALUE_FIELD_BITS-1:0]       req_value,
   input  logic                                        req_last,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [crce_pkg::COST_BITS-1:0]              rsp_running_cost,
   output logic                                        rsp_route_done,
   output logic                                        rsp_status,
   input  logic                                        csr_write_enable,
   input  logic [crce_pkg::LOAD_BITS-1:0]              csr_write_data,
   output crce_pkg::tbl_ctrl_type                      tbl_ctrl,
   output logic [$clog2(MAX_POINTS)-1:0]               wr_row,
   output logic [$clog2(MAX_POINTS)-1:0]               wr_col,
   output logic [VALUE_BITS-1:0]                       wr_data,
   output logic [$clog2(MAX_POINTS)-1:0]               dem_raddr,
   output logic [2*$clog2(MAX_POINTS)-1:0]             dist_raddr,
   input  logic [VALUE_BITS-1:0]                       dem_rdata,
   input  logic [VALUE_BITS-1:0]                       dist_rdata
);
   import crce_pkg::*;

   localparam int PB = $clog2(MAX_POINTS);
   localparam int CW = ((VALUE_BITS > LOAD_BITS) ? VALUE_BITS : LOAD_BITS) + 1;

   function automatic logic [PB-1:0] wrap_point(input logic [POINT_FIELD_BITS-1:0] p);
      logic [31:0] r;
      r = 32'(p);
      for (int k = POINT_FIELD_BITS - 1; k >= 0; k--) begin
         if (r >= (32'(MAX_POINTS) << k)) begin
            r = r - (32'(MAX_POINTS) << k);
         end
      end
      return r[PB-1:0];
   endfunction

   function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                    input logic [VALUE_BITS-1:0] b);
      logic [COST_BITS:0] s;
      s = {1'b0, a} + (COST_BITS + 1)'(b);
      return s[COST_BITS] ? {COST_BITS{1'b1}} : s[COST_BITS-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [LOAD_BITS-1:0]  load_ff, load_in;
   logic [PB-1:0]         prev_ff, prev_in;
   logic [COST_BITS-1:0]  cost_ff, cost_in;
   logic [PB-1:0]         pt_ff, pt_in;
   logic                  last_ff, last_in;
   logic                  skip_ff, skip_in;
   logic [LOAD_BITS-1:0]  cap_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COST_BITS-1:0]  rsp_cost_ff;
   logic                  rsp_done_ff;
   logic                  rsp_status_ff;

   logic                  req_accept;
   logic                  out_free;
   logic [PB-1:0]         row_w;
   logic [PB-1:0]         col_w;
   logic [CW-1:0]         d_ext;
   logic [CW-1:0]         cap_ext;
   logic [CW-1:0]         load_sum;
   logic                  d_skip;
   logic                  d_ovf;
   logic [COST_BITS-1:0]  cost_leg;
   logic                  fin;
   logic                  fin_ok;
   logic [COST_BITS-1:0]  fin_cost;
   logic                  fin_done;
   logic                  fin_status;
   logic                  dist_re;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign row_w   = wrap_point(req_point);
   assign col_w   = wrap_point(req_other_point);
   assign wr_row  = row_w;
   assign wr_col  = col_w;
   assign wr_data = VALUE_BITS'(req_value);
   assign dem_raddr = row_w;

   assign d_ext    = CW'(dem_rdata);
   assign cap_ext  = CW'(cap_ff);
   assign load_sum = CW'(load_ff) + d_ext;
   assign d_skip   = d_ext > cap_ext;
   assign d_ovf    = !d_skip && (load_sum > cap_ext);
   assign cost_leg = sat_add(cost_ff, dist_rdata);

   always_comb begin
      state_in   = state_ff;
      load_in    = load_ff;
      prev_in    = prev_ff;
      cost_in    = cost_ff;
      pt_in      = pt_ff;
      last_in    = last_ff;
      skip_in    = skip_ff;
      dist_re    = 1'b0;
      dist_raddr = {prev_ff, pt_ff};
      fin        = 1'b0;
      fin_cost   = cost_ff;
      fin_done   = 1'b0;
      fin_status = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_VISIT) begin
                  state_in   = ST_EVAL;
                  pt_in      = row_w;
                  last_in    = req_last;
                  dist_re    = 1'b1;
                  dist_raddr = (load_ff == '0) ? {{PB{1'b0}}, row_w} : {prev_ff, row_w};
               end else begin
                  fin = 1'b1;
               end
            end
         end
         ST_EVAL: begin
            if (d_skip) begin
               skip_in = 1'b1;
               if (last_ff && (load_ff != '0)) begin
                  dist_re    = 1'b1;
                  dist_raddr = {prev_ff, {PB{1'b0}}};
                  state_in   = ST_CLOSE;
               end else begin
                  fin        = 1'b1;
                  fin_done   = last_ff;
                  fin_status = 1'b1;
               end
            end else if (d_ovf) begin
               skip_in    = 1'b0;
               dist_re    = 1'b1;
               dist_raddr = {prev_ff, {PB{1'b0}}};
               state_in   = ST_RET;
            end else begin
               skip_in = 1'b0;
               cost_in = cost_leg;
               load_in = LOAD_BITS'(load_sum);
               prev_in = pt_ff;
               if (last_ff && (load_sum != '0)) begin
                  dist_re    = 1'b1;
                  dist_raddr = {pt_ff, {PB{1'b0}}};
                  state_in   = ST_CLOSE;
               end else begin
                  fin      = 1'b1;
                  fin_cost = cost_leg;
                  fin_done = last_ff;
               end
            end
         end
         ST_RET: begin
            cost_in    = cost_leg;
            load_in    = '0;
            dist_re    = 1'b1;
            dist_raddr = {{PB{1'b0}}, pt_ff};
            state_in   = ST_LEG;
         end
         ST_LEG: begin
            cost_in = cost_leg;
            load_in = LOAD_BITS'(dem_rdata);
            prev_in = pt_ff;
            if (last_ff && (dem_rdata != '0)) begin
               dist_re    = 1'b1;
               dist_raddr = {pt_ff, {PB{1'b0}}};
               state_in   = ST_CLOSE;
            end else begin
               fin      = 1'b1;
               fin_cost = cost_leg;
               fin_done = last_ff;
            end
         end
         ST_CLOSE: begin
            fin        = 1'b1;
            fin_cost   = cost_leg;
            fin_done   = 1'b1;
            fin_status = skip_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      fin_ok = fin && out_free;
      if (fin && !out_free) begin
         state_in = state_ff;
         load_in  = load_ff;
         prev_in  = prev_ff;
         cost_in  = cost_ff;
         skip_in  = skip_ff;
      end else if (fin) begin
         state_in = ST_IDLE;
         if (fin_done) begin
            cost_in = '0;
            load_in = '0;
            prev_in = '0;
         end
      end
   end

   assign tbl_ctrl.dem_we  = req_accept && (req_kind == KIND_DEMAND);
   assign tbl_ctrl.dist_we = req_accept && (req_kind == KIND_DIST);
   assign tbl_ctrl.dem_re  = req_accept && (req_kind == KIND_VISIT);
   assign tbl_ctrl.dist_re = dist_re;

   assign rsp_valid_in = fin_ok ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_ff      <= '0;
         prev_ff      <= '0;
         cost_ff      <= '0;
         skip_ff      <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         prev_ff      <= prev_in;
         cost_ff      <= cost_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pt_ff   <= pt_in;
      last_ff <= last_in;
      if (fin_ok) begin
         rsp_cost_ff   <= fin_cost;
         rsp_done_ff   <= fin_done;
         rsp_status_ff <= fin_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_cost = rsp_cost_ff;
   assign rsp_route_done   = rsp_done_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

[rtl/capacitated_route_cost_evaluator.sv]
// Top level of the capacitated route cost evaluator.
//
// Request channel (req_valid / req_stall) carries demand writes, distance
// writes and customer visits; the response channel (rsp_valid / rsp_stall)
// returns one transfer per request with the running cost, a route-done flag
// and a status bit for customers whose demand alone exceeds capacity.
// csr_write_enable / csr_write_data load the vehicle capacity (reset 65535).
// Table writes respond in the cycle after the request transfer. A visit
// reads its leg from the distance table; the last visit adds a read of the
// depot return, a capacity split adds reads of a return and a restart leg,
// and a visit can have both: each extra step is one more read of the single
// distance table port.
// Reset clears the route state and sets the capacity to 65535; the tables
// keep no reset value and entries must be written before they are visited.
// A stalled response is held in the output register; req_stall rises while
// a visit is being evaluated or while the output register is full and stalled.
module capacitated_route_cost_evaluator #(
   parameter int MAX_POINTS = 256,
   parameter int VALUE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [crce_pkg::KIND_BITS-1:0]         req_kind,
   input  logic [crce_pkg::POINT_FIELD_BITS-1:0]  req_point,
   input  logic [crce_pkg::POINT_FIELD_BITS-1:0]  req_other_point,
   input  logic [crce_pkg::VALUE_FIELD_BITS-1:0]  req_value,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [crce_pkg::COST_BITS-1:0]         rsp_running_cost,
   output logic                                   rsp_route_done,
   output logic                                   rsp_status,
   input  logic                                   csr_write_enable,
   input  logic [crce_pkg::LOAD_BITS-1:0]         csr_write_data
);
   import crce_pkg::*;

   localparam int PB = $clog2(MAX_POINTS);

   tbl_ctrl_type          tbl_ctrl;
   logic [PB-1:0]         wr_row;
   logic [PB-1:0]         wr_col;
   logic [VALUE_BITS-1:0] wr_data;
   logic [PB-1:0]         dem_raddr;
   logic [2*PB-1:0]       dist_raddr;
   logic [VALUE_BITS-1:0] dem_rdata;
   logic [VALUE_BITS-1:0] dist_rdata;

   crce_tables #(
      .MAX_POINTS (MAX_POINTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_tables (
      .clock      (clock),
      .tbl_ctrl   (tbl_ctrl),
      .wr_row     (wr_row),
      .wr_col     (wr_col),
      .wr_data    (wr_data),
      .dem_raddr  (dem_raddr),
      .dist_raddr (dist_raddr),
      .dem_rdata  (dem_rdata),
      .dist_rdata (dist_rdata)
   );

   crce_engine #(
      .MAX_POINTS (MAX_POINTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_point        (req_point),
      .req_other_point  (req_other_point),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_running_cost (rsp_running_cost),
      .rsp_route_done   (rsp_route_done),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .tbl_ctrl         (tbl_ctrl),
      .wr_row           (wr_row),
      .wr_col           (wr_col),
      .wr_data          (wr_data),
      .dem_raddr        (dem_raddr),
      .dist_raddr       (dist_raddr),
      .dem_rdata        (dem_rdata),
      .dist_rdata       (dist_rdata)
   );

endmodule
